@@ design/sme_pkg.sv @@
// Package for the stack machine execute block: opcodes, status codes, sequencer states.
// No dependencies.
package sme_pkg;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAR_COUNT_DEF   = 64;
    localparam int CODE_WORDS_DEF  = 4096;
    localparam int PC_W            = 12;
    localparam int LEVEL_W         = 7;

    typedef enum logic [4:0] {
        OP_LT = 5'd0, OP_LE = 5'd1, OP_GT = 5'd2, OP_GE = 5'd3, OP_NE = 5'd4,
        OP_EQ = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_SHL = 5'd8, OP_SHR = 5'd9,
        OP_LOR = 5'd10, OP_LAND = 5'd11, OP_OR = 5'd12, OP_AND = 5'd13,
        OP_XOR = 5'd14, OP_DIV = 5'd15, OP_MOD = 5'd16, OP_MUL = 5'd17,
        OP_PUSHC = 5'd18, OP_SETV = 5'd19, OP_PUSHV = 5'd20, OP_SETS = 5'd21,
        OP_PUSHS = 5'd22, OP_HALT = 5'd23, OP_JT = 5'd24, OP_JF = 5'd25,
        OP_JMP = 5'd26, OP_PRINT = 5'd27, OP_DUP = 5'd28, OP_TRACE = 5'd29,
        OP_U30 = 5'd30, OP_U31 = 5'd31
    } opcode_t;

    localparam logic [1:0] ST_CONT = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_DONE
    } state_t;
endpackage

@@ design/sme_if.sv @@
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; payload width set by parameter.
interface sme_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/sme_div.sv @@
// Radix-2 signed divider, one quotient bit per cycle.
// Depends on nothing.
module sme_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           num,
    input  logic [31:0]           den,
    output logic                  busy,
    output logic [31:0]           quo,
    output logic [31:0]           rem
);
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        nq_reg, nq_next, nr_reg, nr_next;
    logic [32:0] trial;
    logic [31:0] qmag, rmag;

    // One restoring step per cycle on magnitudes
    always_comb
    begin
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        nq_next = nq_reg;
        nr_next = nr_reg;
        trial = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};
        if (start)
        begin
            cnt_next = 6'd32;
            q_next = num[31] ? (~num + 32'd1) : num;
            d_next = den[31] ? (~den + 32'd1) : den;
            r_next = '0;
            nq_next = num[31] ^ den[31];
            nr_next = num[31];
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        nq_reg <= nq_next;
        nr_reg <= nr_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign qmag = q_reg;
    assign rmag = r_reg[31:0];
    assign quo  = nq_reg ? (~qmag + 32'd1) : qmag;
    assign rem  = nr_reg ? (~rmag + 32'd1) : rmag;
endmodule

@@ design/stack_machine_execute_top.sv @@
// Stack machine execute block: 1-item valid/ready in, 1 result out.
// Steps: top read, second (or indexed) read, one shared ALU step or the bit-serial
// divider; the result is held until taken, and only then is the next instruction accepted.
// Reset: stack empty, pc zero, variables read as zero until written (valid bits).
// Depends on sme_pkg, sme_if, sme_div.
module stack_machine_execute_top
#(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = sme_pkg::VAR_COUNT_DEF,
    parameter int CODE_WORDS  = sme_pkg::CODE_WORDS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    sme_if.sink   in_ch,
    sme_if.source out_ch
);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int VA_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int LV_W = $clog2(STACK_DEPTH + 1);
    localparam int CP_W = $clog2(CODE_WORDS);
    localparam int PC_W = sme_pkg::PC_W;
    localparam int LEVEL_W = sme_pkg::LEVEL_W;

    sme_pkg::state_t state_reg, state_next;
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] var_mem [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_vld_reg;
    logic [31:0] srd_reg, vrd_reg;
    logic [VA_W-1:0] vaddr;
    logic [SA_W-1:0] saddr;
    logic        s_we, v_we;
    logic [SA_W-1:0] s_wa;
    logic [31:0] s_wd;

    logic [LV_W-1:0] lvl_reg, lvl_next;
    logic [CP_W-1:0] pc_reg, pc_next;
    logic [4:0]  op_reg;
    logic [31:0] w_reg;
    logic [31:0] a_reg, b_val;
    logic [1:0]  st_reg, st_next;
    logic        pv_reg, pv_next;
    logic [31:0] pval_reg, pval_next;
    logic        ovld_reg;

    // pc advance, wraps at CODE_WORDS
    function automatic logic [CP_W-1:0] pc_plus(input logic [CP_W-1:0] pc_cur,
                                                input logic [1:0] k);
        logic [CP_W:0] s;
        s = {1'b0, pc_cur} + {{(CP_W-1){1'b0}}, k};
        if (s >= (CP_W+1)'(CODE_WORDS))
            s = s - (CP_W+1)'(CODE_WORDS);
        return s[CP_W-1:0];
    endfunction

    // signed operand checks
    logic [33:0] ws;
    logic        w_var_ok, w_pc_ok;
    logic [33:0] idx_push, idx_set;
    assign ws = {{2{w_reg[31]}}, w_reg};
    assign w_var_ok = !w_reg[31] && (ws < 34'(VAR_COUNT));
    assign w_pc_ok  = !w_reg[31] && (ws < 34'(CODE_WORDS));
    assign idx_push = 34'(lvl_reg) - 34'd1 - ws;
    assign idx_set  = 34'(lvl_reg) - 34'd2 - ws;
    logic push_ok, set_ok;
    assign push_ok = !idx_push[33] && (idx_push < 34'(lvl_reg));
    assign set_ok  = !idx_set[33] && (idx_set < 34'(lvl_reg) - 34'd1);

    // second operand: read addressed in RD2, valid in EXEC
    assign b_val = srd_reg;

    logic        div_start, div_busy;
    logic [31:0] quo, rem;

    sme_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(a_reg), .den(b_val),
        .busy(div_busy), .quo(quo), .rem(rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sme_pkg::S_IDLE: if (in_ch.valid) state_next = sme_pkg::S_RD1;
            sme_pkg::S_RD1:  state_next = sme_pkg::S_RD2;
            sme_pkg::S_RD2:  state_next = sme_pkg::S_EXEC;
            sme_pkg::S_EXEC:
                if ((op_reg == 5'(sme_pkg::OP_DIV) || op_reg == 5'(sme_pkg::OP_MOD))
                    && lvl_reg >= LV_W'(2) && b_val != 32'd0)
                    state_next = sme_pkg::S_DIV;
                else
                    state_next = sme_pkg::S_DONE;
            sme_pkg::S_DIV:  if (!div_busy && !div_start) state_next = sme_pkg::S_DONE;
            sme_pkg::S_DONE: if (out_ch.ready) state_next = sme_pkg::S_IDLE;
            default: state_next = sme_pkg::S_IDLE;
        endcase
    end

    // read addresses: top in RD1, second (or indexed) in RD2
    always_comb
    begin
        saddr = SA_W'(lvl_reg - LV_W'(1));
        if (state_reg == sme_pkg::S_RD2)
        begin
            if (op_reg == 5'(sme_pkg::OP_PUSHS))
                saddr = SA_W'(idx_push);
            else
                saddr = SA_W'(lvl_reg - LV_W'(2));
        end
        vaddr = VA_W'(w_reg);
    end

    // shared ALU and execution (outputs block)
    logic [31:0] r;
    logic        err;
    always_comb
    begin
        r = 32'd0;
        err = 1'b0;
        lvl_next = lvl_reg;
        pc_next = pc_reg;
        st_next = st_reg;
        pv_next = pv_reg;
        pval_next = pval_reg;
        s_we = 1'b0;
        s_wa = SA_W'(lvl_reg);
        s_wd = 32'd0;
        v_we = 1'b0;
        div_start = 1'b0;
        if (state_reg == sme_pkg::S_EXEC)
        begin
            st_next = sme_pkg::ST_CONT;
            pv_next = 1'b0;
            pval_next = 32'd0;
            if (op_reg <= 5'(sme_pkg::OP_MUL))
            begin
                case (op_reg)
                    5'(sme_pkg::OP_LT):   r = {31'd0, $signed(a_reg) <  $signed(b_val)};
                    5'(sme_pkg::OP_LE):   r = {31'd0, $signed(a_reg) <= $signed(b_val)};
                    5'(sme_pkg::OP_GT):   r = {31'd0, $signed(a_reg) >  $signed(b_val)};
                    5'(sme_pkg::OP_GE):   r = {31'd0, $signed(a_reg) >= $signed(b_val)};
                    5'(sme_pkg::OP_NE):   r = {31'd0, a_reg != b_val};
                    5'(sme_pkg::OP_EQ):   r = {31'd0, a_reg == b_val};
                    5'(sme_pkg::OP_ADD):  r = a_reg + b_val;
                    5'(sme_pkg::OP_SUB):  r = a_reg - b_val;
                    5'(sme_pkg::OP_SHL):  r = a_reg << b_val[4:0];
                    5'(sme_pkg::OP_SHR):  r = 32'($signed(a_reg) >>> b_val[4:0]);
                    5'(sme_pkg::OP_LOR):  r = {31'd0, (a_reg != 0) || (b_val != 0)};
                    5'(sme_pkg::OP_LAND): r = {31'd0, (a_reg != 0) && (b_val != 0)};
                    5'(sme_pkg::OP_OR):   r = a_reg | b_val;
                    5'(sme_pkg::OP_AND):  r = a_reg & b_val;
                    5'(sme_pkg::OP_XOR):  r = a_reg ^ b_val;
                    5'(sme_pkg::OP_MUL):  r = a_reg * b_val;
                    default:              r = 32'd0;
                endcase
                if (lvl_reg < LV_W'(2))
                    err = 1'b1;
                else if (op_reg == 5'(sme_pkg::OP_DIV) || op_reg == 5'(sme_pkg::OP_MOD))
                begin
                    if (b_val == 32'd0) err = 1'b1;
                    else div_start = 1'b1;
                end
                else
                begin
                    s_we = 1'b1;
                    s_wa = SA_W'(lvl_reg - LV_W'(2));
                    s_wd = r;
                    lvl_next = lvl_reg - LV_W'(1);
                    pc_next = pc_plus(pc_reg, 2'd1);
                end
            end
            else
            begin
                case (op_reg)
                    5'(sme_pkg::OP_PUSHC):
                        if (lvl_reg >= LV_W'(STACK_DEPTH)) err = 1'b1;
                        else
                        begin
                            s_we = 1'b1; s_wd = w_reg;
                            lvl_next = lvl_reg + LV_W'(1); pc_next = pc_plus(pc_reg, 2'd2);
                        end
                    5'(sme_pkg::OP_SETV):
                        if (lvl_reg < LV_W'(1) || !w_var_ok) err = 1'b1;
                        else
                        begin
                            v_we = 1'b1;
                            lvl_next = lvl_reg - LV_W'(1); pc_next = pc_plus(pc_reg, 2'd2);
                        end
                    5'(sme_pkg::OP_PUSHV):
                        if (lvl_reg >= LV_W'(STACK_DEPTH) || !w_var_ok) err = 1'b1;
                        else
                        begin
                            s_we = 1'b1;
                            s_wd = var_vld_reg[vaddr] ? vrd_reg : 32'd0;
                            lvl_next = lvl_reg + LV_W'(1); pc_next = pc_plus(pc_reg, 2'd2);
                        end
                    5'(sme_pkg::OP_SETS):
                        if (lvl_reg < LV_W'(1) || !set_ok) err = 1'b1;
                        else
                        begin
                            s_we = 1'b1; s_wa = SA_W'(idx_set); s_wd = a_reg;
                            lvl_next = lvl_reg - LV_W'(1); pc_next = pc_plus(pc_reg, 2'd2);
                        end
                    5'(sme_pkg::OP_PUSHS):
                        if (lvl_reg >= LV_W'(STACK_DEPTH) || !push_ok) err = 1'b1;
                        else
                        begin
                            s_we = 1'b1; s_wd = b_val;
                            lvl_next = lvl_reg + LV_W'(1); pc_next = pc_plus(pc_reg, 2'd2);
                        end
                    5'(sme_pkg::OP_HALT): st_next = sme_pkg::ST_HALT;
                    5'(sme_pkg::OP_JT), 5'(sme_pkg::OP_JF):
                        if (lvl_reg < LV_W'(1)) err = 1'b1;
                        else if ((a_reg != 32'd0) == (op_reg == 5'(sme_pkg::OP_JT)))
                        begin
                            if (!w_pc_ok) err = 1'b1;
                            else
                            begin
                                lvl_next = lvl_reg - LV_W'(1); pc_next = CP_W'(w_reg);
                            end
                        end
                        else
                        begin
                            lvl_next = lvl_reg - LV_W'(1); pc_next = pc_plus(pc_reg, 2'd2);
                        end
                    5'(sme_pkg::OP_JMP):
                        if (!w_pc_ok) err = 1'b1;
                        else pc_next = CP_W'(w_reg);
                    5'(sme_pkg::OP_PRINT):
                        if (lvl_reg < LV_W'(1)) err = 1'b1;
                        else
                        begin
                            pv_next = 1'b1; pval_next = a_reg;
                            lvl_next = lvl_reg - LV_W'(1); pc_next = pc_plus(pc_reg, 2'd1);
                        end
                    5'(sme_pkg::OP_DUP):
                        if (lvl_reg < LV_W'(1) || lvl_reg >= LV_W'(STACK_DEPTH)) err = 1'b1;
                        else
                        begin
                            s_we = 1'b1; s_wd = a_reg;
                            lvl_next = lvl_reg + LV_W'(1); pc_next = pc_plus(pc_reg, 2'd1);
                        end
                    5'(sme_pkg::OP_TRACE): pc_next = pc_plus(pc_reg, 2'd1);
                    default: err = 1'b1;
                endcase
            end
            if (err)
            begin
                st_next = sme_pkg::ST_ERR;
                lvl_next = lvl_reg;
                pc_next = pc_reg;
                s_we = 1'b0;
                v_we = 1'b0;
                pv_next = 1'b0;
                pval_next = 32'd0;
            end
        end
        else if (state_reg == sme_pkg::S_DIV && !div_busy)
        begin
            s_we = 1'b1;
            s_wa = SA_W'(lvl_reg - LV_W'(2));
            s_wd = (op_reg == 5'(sme_pkg::OP_DIV)) ? quo : rem;
            lvl_next = lvl_reg - LV_W'(1);
            pc_next = pc_plus(pc_reg, 2'd1);
        end
    end

    // memories: one read port each, registered
    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_wa] <= s_wd;
        srd_reg <= stack_mem[saddr];
        if (v_we)
            var_mem[vaddr] <= a_reg;
        vrd_reg <= var_mem[vaddr];
    end

    // capture request and top operand
    always_ff @(posedge clk)
    begin
        if (state_reg == sme_pkg::S_IDLE && in_ch.valid)
        begin
            op_reg <= in_ch.data[36:32];
            w_reg  <= in_ch.data[31:0];
        end
        if (state_reg == sme_pkg::S_RD2) a_reg <= srd_reg;
        pval_reg <= pval_next;
    end

    // top is read in RD1 and held in a_reg; the second read (RD2) is used
    // straight from srd_reg during EXEC.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sme_pkg::S_IDLE;
            lvl_reg <= '0;
            pc_reg <= '0;
            st_reg <= sme_pkg::ST_CONT;
            pv_reg <= 1'b0;
            var_vld_reg <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg <= lvl_next;
            pc_reg <= pc_next;
            st_reg <= st_next;
            pv_reg <= pv_next;
            if (v_we) var_vld_reg[vaddr] <= 1'b1;
            ovld_reg <= (state_next == sme_pkg::S_DONE);
        end
    end

    assign in_ch.ready  = (state_reg == sme_pkg::S_IDLE);
    assign out_ch.valid = ovld_reg;
    assign out_ch.data  = {st_reg, PC_W'(pc_reg), pv_reg, pval_reg, LEVEL_W'(lvl_reg)};

`ifndef SYNTHESIS
    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LV_W'(STACK_DEPTH)) else $error("stack level overflow");
    a_vld: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid == (state_reg == sme_pkg::S_DONE)) else $error("valid/state mismatch");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sme_pkg::S_EXEC && err) |=> $stable(lvl_reg) && $stable(pc_reg))
        else $error("error changed state");
    a_pv: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && pv_reg |-> st_reg == sme_pkg::ST_CONT) else $error("print on error");
`endif
endmodule

@@ tb/sme_checker.sv @@
// Checker for the stack machine execute block: watches both channels,
// predicts each result from accepted requests and compares field by field.
// Depends on sme_pkg and sme_if.
module sme_checker
(
    input  logic   clk,
    input  logic   rst_n,
    sme_if         req_ch,
    sme_if         res_ch,
    output int     fail_count,
    output int     pending
);
    localparam int DEPTH = sme_pkg::STACK_DEPTH_DEF;
    localparam int NVARS = sme_pkg::VAR_COUNT_DEF;
    localparam int NCODE = sme_pkg::CODE_WORDS_DEF;
    localparam int PC_W = sme_pkg::PC_W;
    localparam int LEVEL_W = sme_pkg::LEVEL_W;

    typedef struct packed {
        logic [1:0]         status;
        logic [PC_W-1:0]    next_pc;
        logic               print_valid;
        logic [31:0]        print_value;
        logic [LEVEL_W-1:0] stack_level;
    } sme_result_t;

    logic [31:0]        stk [DEPTH];
    logic [31:0]        vars [NVARS];
    int unsigned        level;
    logic [PC_W-1:0]    pc;
    sme_result_t        expected_q [$];

    function automatic logic [PC_W-1:0] pc_add(input int unsigned k);
        return PC_W'((pc + k) % NCODE);
    endfunction

    // Execute one instruction on the shadow machine.
    function automatic sme_result_t execute(input sme_pkg::opcode_t op,
                                            input logic [31:0] wb);
        sme_result_t res;
        longint      w;
        longint      sa;
        longint      sb;
        longint      idx;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic        err;
        logic        take;
        logic [PC_W-1:0] npc;
        w   = longint'($signed(wb));
        err = 1'b0;
        npc = pc;
        res = '0;
        r   = '0;
        if (op <= sme_pkg::OP_MUL) begin
            if (level < 2) err = 1'b1;
            else
            begin
                a  = stk[level-1];
                b  = stk[level-2];
                sa = longint'($signed(a));
                sb = longint'($signed(b));
                case (op)
                    sme_pkg::OP_LT:   r = 32'(sa < sb);
                    sme_pkg::OP_LE:   r = 32'(sa <= sb);
                    sme_pkg::OP_GT:   r = 32'(sa > sb);
                    sme_pkg::OP_GE:   r = 32'(sa >= sb);
                    sme_pkg::OP_NE:   r = 32'(a != b);
                    sme_pkg::OP_EQ:   r = 32'(a == b);
                    sme_pkg::OP_ADD:  r = a + b;
                    sme_pkg::OP_SUB:  r = a - b;
                    sme_pkg::OP_SHL:  r = a << b[4:0];
                    sme_pkg::OP_SHR:  r = $unsigned($signed(a) >>> b[4:0]);
                    sme_pkg::OP_LOR:  r = 32'((a != 0) || (b != 0));
                    sme_pkg::OP_LAND: r = 32'((a != 0) && (b != 0));
                    sme_pkg::OP_OR:   r = a | b;
                    sme_pkg::OP_AND:  r = a & b;
                    sme_pkg::OP_XOR:  r = a ^ b;
                    sme_pkg::OP_DIV, sme_pkg::OP_MOD:
                    begin
                        if (b == 0) err = 1'b1;
                        else if (op == sme_pkg::OP_DIV) r = 32'(sa / sb);
                        else r = 32'(sa % sb);
                    end
                    default: r = a * b;
                endcase
                if (!err)
                begin
                    stk[level-2] = r;
                    level = level - 1;
                    npc = pc_add(1);
                end
            end
        end
        else
        begin
            case (op)
                sme_pkg::OP_PUSHC:
                    if (level >= DEPTH) err = 1'b1;
                    else
                    begin
                        stk[level] = wb;
                        level = level + 1;
                        npc = pc_add(2);
                    end
                sme_pkg::OP_SETV:
                    if (level < 1 || w < 0 || w >= NVARS) err = 1'b1;
                    else
                    begin
                        vars[w] = stk[level-1];
                        level = level - 1;
                        npc = pc_add(2);
                    end
                sme_pkg::OP_PUSHV:
                    if (level >= DEPTH || w < 0 || w >= NVARS) err = 1'b1;
                    else
                    begin
                        stk[level] = vars[w];
                        level = level + 1;
                        npc = pc_add(2);
                    end
                sme_pkg::OP_SETS:
                begin
                    idx = longint'(level) - 2 - w;
                    if (level < 1 || idx < 0 || idx >= longint'(level) - 1) err = 1'b1;
                    else
                    begin
                        stk[idx] = stk[level-1];
                        level = level - 1;
                        npc = pc_add(2);
                    end
                end
                sme_pkg::OP_PUSHS:
                begin
                    idx = longint'(level) - 1 - w;
                    if (level >= DEPTH || idx < 0 || idx >= longint'(level)) err = 1'b1;
                    else
                    begin
                        stk[level] = stk[idx];
                        level = level + 1;
                        npc = pc_add(2);
                    end
                end
                sme_pkg::OP_HALT: res.status = sme_pkg::ST_HALT;
                sme_pkg::OP_JT, sme_pkg::OP_JF:
                    if (level < 1) err = 1'b1;
                    else
                    begin
                        take = (stk[level-1] != 0) == (op == sme_pkg::OP_JT);
                        if (take && (w < 0 || w >= NCODE)) err = 1'b1;
                        else
                        begin
                            level = level - 1;
                            npc = take ? PC_W'(w) : pc_add(2);
                        end
                    end
                sme_pkg::OP_JMP:
                    if (w < 0 || w >= NCODE) err = 1'b1;
                    else npc = PC_W'(w);
                sme_pkg::OP_PRINT:
                    if (level < 1) err = 1'b1;
                    else
                    begin
                        res.print_valid = 1'b1;
                        res.print_value = stk[level-1];
                        level = level - 1;
                        npc = pc_add(1);
                    end
                sme_pkg::OP_DUP:
                    if (level < 1 || level >= DEPTH) err = 1'b1;
                    else
                    begin
                        stk[level] = stk[level-1];
                        level = level + 1;
                        npc = pc_add(1);
                    end
                sme_pkg::OP_TRACE: npc = pc_add(1);
                default: err = 1'b1;
            endcase
        end
        if (err)
        begin
            res.status = sme_pkg::ST_ERR;
            res.print_valid = 1'b0;
            res.print_value = '0;
            npc = pc;
        end
        pc = npc;
        res.next_pc = npc;
        res.stack_level = LEVEL_W'(level);
        return res;
    endfunction

    assign pending = expected_q.size();

    // Predict on every accepted request, compare every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        sme_result_t got;
        sme_result_t exp_r;
        if (!rst_n)
        begin
            level = 0;
            pc = '0;
            for (int i = 0; i < NVARS; i++) vars[i] = '0;
            for (int i = 0; i < DEPTH; i++) stk[i] = '0;
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.status !== exp_r.status)
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                    if (got.next_pc !== exp_r.next_pc)
                        $display("%0t: next_pc exp %0d got %0d", $time, exp_r.next_pc,
                                 got.next_pc);
                    if (got.print_valid !== exp_r.print_valid)
                        $display("%0t: print_valid exp %0d got %0d", $time,
                                 exp_r.print_valid, got.print_valid);
                    if (got.print_value !== exp_r.print_value)
                        $display("%0t: print_value exp %h got %h", $time,
                                 exp_r.print_value, got.print_value);
                    if (got.stack_level !== exp_r.stack_level)
                        $display("%0t: stack_level exp %0d got %0d", $time,
                                 exp_r.stack_level, got.stack_level);
                    if (got !== exp_r) fail_count <= fail_count + 1;
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_q.push_back(execute(sme_pkg::opcode_t'(req_ch.data[36:32]),
                                             req_ch.data[31:0]));
        end
    end
endmodule

@@ tb/testbench.sv @@
// Top of the stack machine execute testbench: clock, reset, request stimulus,
// result stalls and the verdict. Depends on sme_pkg, sme_if, sme_checker and the block.
module testbench;
    localparam int LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   burst_left = 0;

    sme_if #(.W(37)) req_ch ();
    sme_if #(.W(54)) res_ch ();

    stack_machine_execute_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (res_ch)
    );

    sme_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_ch     (req_ch),
        .res_ch     (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // Run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result-side stalls: phases of free flow, light and heavy stalling
    initial
    begin
        int mode;
        res_ch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60))
            begin
                @(negedge clk);
                case (mode)
                    0: res_ch.ready = 1'b1;
                    1: res_ch.ready = ($urandom_range(0, 3) != 0);
                    default: res_ch.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Send one request, then maybe open a gap
    task automatic send_req(input sme_pkg::opcode_t op, input logic [31:0] w);
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.data  = {op, w};
        do @(posedge clk); while (!req_ch.ready);
        if (burst_left > 0) burst_left--;
        else
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    function automatic logic [31:0] rand_const();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // Operand for a given opcode: mostly in range, sometimes wild
    function automatic logic [31:0] rand_operand(input sme_pkg::opcode_t op);
        if ($urandom_range(0, 15) == 0) return $urandom;
        case (op)
            sme_pkg::OP_PUSHC: return rand_const();
            sme_pkg::OP_SETV, sme_pkg::OP_PUSHV: return $urandom_range(0, 66);
            sme_pkg::OP_SETS, sme_pkg::OP_PUSHS: return 32'(int'($urandom_range(0, 12)) - 2);
            sme_pkg::OP_JT, sme_pkg::OP_JF, sme_pkg::OP_JMP: return $urandom_range(0, 4097);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        sme_pkg::opcode_t op;
        int      pick;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: underflow, extremes, every non-arithmetic opcode, divide corner cases
        send_req(sme_pkg::OP_ADD, 32'd0);
        send_req(sme_pkg::OP_PRINT, 32'd0);
        send_req(sme_pkg::OP_PUSHC, 32'hffff_ffff);
        send_req(sme_pkg::OP_PUSHC, 32'h8000_0000);
        send_req(sme_pkg::OP_DIV, 32'd0);
        send_req(sme_pkg::OP_PUSHC, 32'd0);
        send_req(sme_pkg::OP_PUSHC, 32'd7);
        send_req(sme_pkg::OP_DIV, 32'd0);
        send_req(sme_pkg::OP_PUSHC, 32'hffff_ffff);
        send_req(sme_pkg::OP_PUSHC, 32'h8000_0000);
        send_req(sme_pkg::OP_MOD, 32'd0);
        send_req(sme_pkg::OP_PUSHS, 32'd0);
        send_req(sme_pkg::OP_SETV, 32'd63);
        send_req(sme_pkg::OP_PUSHV, 32'd63);
        send_req(sme_pkg::OP_PUSHV, 32'd64);
        send_req(sme_pkg::OP_SETS, 32'd0);
        send_req(sme_pkg::OP_DUP, 32'd0);
        send_req(sme_pkg::OP_JT, 32'd4095);
        send_req(sme_pkg::OP_JF, 32'hffff_ffff);
        send_req(sme_pkg::OP_JMP, 32'd4096);
        send_req(sme_pkg::OP_JMP, 32'd4094);
        send_req(sme_pkg::OP_TRACE, 32'd0);
        send_req(sme_pkg::OP_TRACE, 32'd0);
        send_req(sme_pkg::OP_HALT, 32'd0);
        send_req(sme_pkg::OP_U30, 32'd0);
        send_req(sme_pkg::OP_U31, 32'hffff_ffff);

        // Random programs
        for (int i = 0; i < 1800; i++)
        begin
            if (i == 900)
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
                wait (pending == 0);
                repeat (40) @(negedge clk);
            end
            if ($urandom_range(0, 999) == 0)
            begin
                // Fill the stack past its depth
                repeat (66) send_req(sme_pkg::OP_PUSHC, $urandom);
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) op = sme_pkg::OP_PUSHC;
            else if (pick < 75) op = sme_pkg::opcode_t'($urandom_range(0, 17));
            else op = sme_pkg::opcode_t'($urandom_range(18, 31));
            send_req(op, rand_operand(op));
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
design/sme_pkg.sv
design/sme_if.sv
design/sme_div.sv
design/stack_machine_execute_top.sv
tb/sme_checker.sv
tb/testbench.sv
